/* rtl/vlq_base128_codec_assert.svh */
// assertion macros used by the vlq codec datapath
`ifndef VLQ_BASE128_CODEC_ASSERT_SVH
`define VLQ_BASE128_CODEC_ASSERT_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define VLQ_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("vlq assertion failed");

// next-cycle implication, sampled on clk, off while rst_n is low
`define VLQ_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("vlq assertion failed");

`endif

/* rtl/vlq_pkg.sv */
// shared constants, codes and control types of the vlq base-128 codec
package vlq_pkg;

  // width of the decode accumulator and of the encoded value, 8 to 64
  localparam int VALUE_WIDTH = 64;
  // number of 7-bit groups a value can span
  localparam int GRP_CNT     = (VALUE_WIDTH + 6) / 7;
  localparam int PAD_W       = GRP_CNT * 7;
  localparam int IDX_W       = (GRP_CNT > 1) ? $clog2(GRP_CNT) : 1;
  localparam int CNT_W       = $clog2(GRP_CNT + 1);

  localparam logic [7:0] GROUP_MASK = 8'h7F;
  localparam logic [7:0] MORE_BIT   = 8'h80;

  typedef enum logic {
    OP_DECODE = 1'b0,
    OP_ENCODE = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    STAT_OK     = 2'd0,
    STAT_TRUNC  = 2'd1,
    STAT_NOROOM = 2'd2
  } stat_t;

  typedef enum logic {
    S_IDLE,
    S_ENC
  } fsm_t;

  // controller to datapath
  typedef struct packed {
    logic dec_step;
    logic enc_start;
    logic enc_err;
    logic enc_emit;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic out_free;
    logic enc_fit;
    logic enc_final;
  } sts_t;

endpackage

/* rtl/vlq_in_if.sv */
// input item channel of the vlq codec
interface vlq_in_if;
  logic        valid;
  logic        ready;
  logic        op;
  logic [7:0]  data_byte;
  logic        buffer_end;
  logic [63:0] plain_value;
  logic [3:0]  room;

  modport source (output valid, output op, output data_byte, output buffer_end,
                  output plain_value, output room, input ready);
  modport sink   (input valid, input op, input data_byte, input buffer_end,
                  input plain_value, input room, output ready);
endinterface

/* rtl/vlq_out_if.sv */
// result item channel of the vlq codec
interface vlq_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] decoded_value;
  logic [7:0]  byte_count;
  logic [7:0]  code_byte;
  logic [1:0]  status;
  logic        last;

  modport source (output valid, output decoded_value, output byte_count,
                  output code_byte, output status, output last, input ready);
  modport sink   (input valid, input decoded_value, input byte_count,
                  input code_byte, input status, input last, output ready);
endinterface

/* rtl/vlq_base128_codec.sv */
// top level of the base-128 variable-length integer codec
//
//  channel  | dir | handshake          | payload
//  ---------+-----+--------------------+---------------------------------------------
//  in_ch    | in  | valid/ready        | op, data_byte, buffer_end, plain_value, room
//  out_ch   | out | valid/ready        | decoded_value, byte_count, code_byte, status, last
//
// decode takes one byte per cycle while the output is free; a result item appears the
// cycle after the byte that ends its number. encode sizes the value when the item is
// taken, then sends one byte per cycle from the group shifter while the output is free;
// a no-room item gives a single result. a single output register parts the sides;
// outside an encode, a new item is taken in the cycle the waiting result leaves.
// a stalled output holds the input and the encode sequencer; reset is synchronous,
// clears the accumulator and byte count at once, and needs no clearing pass.
module vlq_base128_codec (
  input  logic  clk,
  input  logic  rst_n,
  vlq_in_if.sink    in_ch,
  vlq_out_if.source out_ch
);

  vlq_pkg::cmd_t cmd;
  vlq_pkg::sts_t sts;

  // controller
  vlq_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_op    (in_ch.op),
    .in_ready (in_ch.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // datapath
  vlq_dp u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .sts           (sts),
    .data_byte     (in_ch.data_byte),
    .buffer_end    (in_ch.buffer_end),
    .plain_value   (in_ch.plain_value),
    .room          (in_ch.room),
    .out_ready     (out_ch.ready),
    .out_valid     (out_ch.valid),
    .decoded_value (out_ch.decoded_value),
    .byte_count    (out_ch.byte_count),
    .code_byte     (out_ch.code_byte),
    .status        (out_ch.status),
    .last          (out_ch.last)
  );

endmodule

/* rtl/vlq_ctrl.sv */
// controller: sequences decode steps and encode byte emission
module vlq_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  input  logic          in_op,
  output logic          in_ready,
  input  vlq_pkg::sts_t sts,
  output vlq_pkg::cmd_t cmd
);

  vlq_pkg::fsm_t state_r, state_nxt;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= vlq_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      vlq_pkg::S_IDLE: begin
        in_ready = sts.out_free;
        if (in_valid && sts.out_free) begin
          if (vlq_pkg::op_t'(in_op) == vlq_pkg::OP_DECODE) begin
            cmd.dec_step = 1'b1;
          end else if (sts.enc_fit) begin
            cmd.enc_start = 1'b1;
            state_nxt     = vlq_pkg::S_ENC;
          end else begin
            cmd.enc_err = 1'b1;
          end
        end
      end
      vlq_pkg::S_ENC: begin
        if (sts.out_free) begin
          cmd.enc_emit = 1'b1;
          if (sts.enc_final) begin
            state_nxt = vlq_pkg::S_IDLE;
          end
        end
      end
      default: begin
        state_nxt = vlq_pkg::S_IDLE;
      end
    endcase
  end

endmodule

/* rtl/vlq_dp.sv */
// datapath: decode accumulator, encode group shifter and result register
`include "vlq_base128_codec_assert.svh"

module vlq_dp (
  input  logic          clk,
  input  logic          rst_n,
  input  vlq_pkg::cmd_t cmd,
  output vlq_pkg::sts_t sts,
  input  logic [7:0]    data_byte,
  input  logic          buffer_end,
  input  logic [63:0]   plain_value,
  input  logic [3:0]    room,
  input  logic          out_ready,
  output logic          out_valid,
  output logic [63:0]   decoded_value,
  output logic [7:0]    byte_count,
  output logic [7:0]    code_byte,
  output logic [1:0]    status,
  output logic          last
);

  // decode state
  logic [vlq_pkg::VALUE_WIDTH-1:0] acc_r, acc_nxt;
  logic [7:0]                      seen_r, seen_nxt;
  // encode state
  logic [vlq_pkg::PAD_W-1:0]       pad_r, pad_nxt;
  logic [vlq_pkg::IDX_W-1:0]       idx_r, idx_nxt;
  logic [vlq_pkg::CNT_W-1:0]       num_r, num_nxt;
  // result register
  logic                            ov_r, ov_nxt;
  logic [63:0]                     val_r, val_nxt;
  logic [7:0]                      bcnt_r, bcnt_nxt;
  logic [7:0]                      code_r, code_nxt;
  vlq_pkg::stat_t                  stat_r, stat_nxt;
  logic                            last_r, last_nxt;

  logic [vlq_pkg::VALUE_WIDTH-1:0] acc_shift;
  logic [7:0]                      seen_inc;
  logic [vlq_pkg::PAD_W-1:0]       v_pad;
  logic [vlq_pkg::CNT_W-1:0]       enc_num;
  logic [6:0]                      grp;
  logic                            enc_final;

  // decode: shift in the low seven bits, saturating byte count
  assign acc_shift = {acc_r[vlq_pkg::VALUE_WIDTH-8:0], data_byte[6:0]};
  assign seen_inc  = (seen_r == 8'hFF) ? 8'hFF : seen_r + 8'd1;

  // encode: number of groups up to the highest nonzero one
  assign v_pad = vlq_pkg::PAD_W'(plain_value[vlq_pkg::VALUE_WIDTH-1:0]);
  always_comb begin
    enc_num = vlq_pkg::CNT_W'(1);
    for (int g = 1; g < vlq_pkg::GRP_CNT; g++) begin
      if (v_pad[7*g +: 7] != 7'd0) begin
        enc_num = vlq_pkg::CNT_W'(g + 1);
      end
    end
  end

  // current group, most significant first
  always_comb begin
    grp = 7'd0;
    for (int g = 0; g < vlq_pkg::GRP_CNT; g++) begin
      if (idx_r == vlq_pkg::IDX_W'(g)) begin
        grp = pad_r[7*g +: 7];
      end
    end
  end

  assign enc_final     = (idx_r == '0);
  assign sts.out_free  = !ov_r || out_ready;
  assign sts.enc_fit   = (room != 4'd0) && (8'(room) >= 8'(enc_num));
  assign sts.enc_final = enc_final;

  // next values
  always_comb begin
    acc_nxt  = acc_r;
    seen_nxt = seen_r;
    pad_nxt  = pad_r;
    idx_nxt  = idx_r;
    num_nxt  = num_r;
    ov_nxt   = ov_r && !out_ready;
    val_nxt  = val_r;
    bcnt_nxt = bcnt_r;
    code_nxt = code_r;
    stat_nxt = stat_r;
    last_nxt = last_r;

    if (cmd.dec_step) begin
      if (!data_byte[7] || buffer_end) begin
        ov_nxt   = 1'b1;
        val_nxt  = 64'(acc_shift);
        bcnt_nxt = data_byte[7] ? 8'd0 : seen_inc;
        code_nxt = 8'd0;
        stat_nxt = data_byte[7] ? vlq_pkg::STAT_TRUNC : vlq_pkg::STAT_OK;
        last_nxt = 1'b1;
        acc_nxt  = '0;
        seen_nxt = 8'd0;
      end else begin
        acc_nxt  = acc_shift;
        seen_nxt = seen_inc;
      end
    end

    if (cmd.enc_err) begin
      ov_nxt   = 1'b1;
      val_nxt  = 64'd0;
      bcnt_nxt = 8'd0;
      code_nxt = 8'd0;
      stat_nxt = vlq_pkg::STAT_NOROOM;
      last_nxt = 1'b1;
    end

    if (cmd.enc_start) begin
      pad_nxt = v_pad;
      idx_nxt = vlq_pkg::IDX_W'(enc_num - vlq_pkg::CNT_W'(1));
      num_nxt = enc_num;
    end

    if (cmd.enc_emit) begin
      ov_nxt   = 1'b1;
      val_nxt  = 64'd0;
      bcnt_nxt = 8'(num_r);
      code_nxt = enc_final ? {1'b0, grp} : ({1'b0, grp} | vlq_pkg::MORE_BIT);
      stat_nxt = vlq_pkg::STAT_OK;
      last_nxt = enc_final;
      idx_nxt  = idx_r - vlq_pkg::IDX_W'(1);
    end
  end

  // control and decode state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r  <= '0;
      seen_r <= 8'd0;
      ov_r   <= 1'b0;
    end else begin
      acc_r  <= acc_nxt;
      seen_r <= seen_nxt;
      ov_r   <= ov_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    pad_r  <= pad_nxt;
    idx_r  <= idx_nxt;
    num_r  <= num_nxt;
    val_r  <= val_nxt;
    bcnt_r <= bcnt_nxt;
    code_r <= code_nxt;
    stat_r <= stat_nxt;
    last_r <= last_nxt;
  end

  assign out_valid     = ov_r;
  assign decoded_value = val_r;
  assign byte_count    = bcnt_r;
  assign code_byte     = code_r;
  assign status        = stat_r;
  assign last          = last_r;

  // checks
  `VLQ_ASSERT_IMP(a_ok_has_count, ov_r && stat_r == vlq_pkg::STAT_OK, bcnt_r != 8'd0)
  `VLQ_ASSERT_IMP(a_noroom_shape, ov_r && stat_r == vlq_pkg::STAT_NOROOM, bcnt_r == 8'd0 && code_r == 8'd0 && last_r)
  `VLQ_ASSERT_NXT(a_term_clears, cmd.dec_step && !data_byte[7], acc_r == '0 && seen_r == 8'd0)
  `VLQ_ASSERT_NXT(a_start_index, cmd.enc_start, vlq_pkg::CNT_W'(idx_r) == num_r - vlq_pkg::CNT_W'(1))

endmodule

/* dv/vlq_base128_codec_test.sv */
// self-checking testbench of the base-128 variable-length integer codec
`timescale 1ns / 100ps

module vlq_base128_codec_test;

  localparam int HOLD_CYCLES = 120;
  localparam int SETTLE_CYCLES = 16;
  localparam int RAND_ITEMS = 110;
  localparam int SAT_RUN = 260;
  localparam longint LIMIT_NS = 5_000_000;
  localparam logic [63:0] VALUE_MASK =
    64'hFFFF_FFFF_FFFF_FFFF >> (64 - vlq_pkg::VALUE_WIDTH);

  typedef struct packed {
    vlq_pkg::op_t op;
    logic [7:0]   data;
    logic         buf_end;
    logic [63:0]  value;
    logic [3:0]   room;
  } vlq_item_t;

  typedef struct packed {
    logic [63:0]    value;
    logic [7:0]     count;
    logic [7:0]     code;
    vlq_pkg::stat_t status;
    logic           last;
  } vlq_result_t;

  typedef struct packed {
    vlq_item_t   item;
    logic        typed;
    vlq_result_t want;
  } step_row_t;

  typedef enum {RX_OPEN, RX_MOSTLY, RX_COIN, RX_SPARSE} rx_mode_t;

  localparam vlq_result_t NOROOM_RES = '{64'd0, 8'd0, 8'h00, vlq_pkg::STAT_NOROOM, 1'b1};

  // directed rows: item, whether the result is typed in, and that result
  localparam step_row_t DIRECTED [15] = '{
    // lone terminator right after reset
    '{'{vlq_pkg::OP_DECODE, 8'h00, 1'b0, 64'd0, 4'd0}, 1'b1,
      '{64'd0, 8'd1, 8'h00, vlq_pkg::STAT_OK, 1'b1}},
    // terminator on the buffer end still ends the number
    '{'{vlq_pkg::OP_DECODE, 8'h7F, 1'b1, 64'd0, 4'd0}, 1'b1,
      '{64'h7F, 8'd1, 8'h00, vlq_pkg::STAT_OK, 1'b1}},
    // continuation bit on the last buffer byte
    '{'{vlq_pkg::OP_DECODE, 8'h80, 1'b1, 64'd0, 4'd0}, 1'b1,
      '{64'd0, 8'd0, 8'h00, vlq_pkg::STAT_TRUNC, 1'b1}},
    '{'{vlq_pkg::OP_DECODE, 8'h81, 1'b0, 64'd0, 4'd0}, 1'b0, '0},
    // encode with zero room in the middle of a number
    '{'{vlq_pkg::OP_ENCODE, 8'h00, 1'b0, 64'd5, 4'd0}, 1'b1, NOROOM_RES},
    '{'{vlq_pkg::OP_DECODE, 8'h00, 1'b0, 64'd0, 4'd0}, 1'b1,
      '{64'h80, 8'd2, 8'h00, vlq_pkg::STAT_OK, 1'b1}},
    '{'{vlq_pkg::OP_DECODE, 8'hFF, 1'b0, 64'd0, 4'd0}, 1'b0, '0},
    '{'{vlq_pkg::OP_DECODE, 8'hFF, 1'b1, 64'd0, 4'd0}, 1'b1,
      '{64'h3FFF, 8'd0, 8'h00, vlq_pkg::STAT_TRUNC, 1'b1}},
    '{'{vlq_pkg::OP_ENCODE, 8'h00, 1'b0, 64'd0, 4'd1}, 1'b1,
      '{64'd0, 8'd1, 8'h00, vlq_pkg::STAT_OK, 1'b1}},
    '{'{vlq_pkg::OP_ENCODE, 8'h00, 1'b0, 64'h7F, 4'd15}, 1'b1,
      '{64'd0, 8'd1, 8'h7F, vlq_pkg::STAT_OK, 1'b1}},
    // one byte short of room
    '{'{vlq_pkg::OP_ENCODE, 8'h00, 1'b0, 64'h80, 4'd1}, 1'b1, NOROOM_RES},
    '{'{vlq_pkg::OP_ENCODE, 8'h00, 1'b0, 64'h80, 4'd2}, 1'b0, '0},
    '{'{vlq_pkg::OP_ENCODE, 8'h00, 1'b0, 64'hFFFF_FFFF_FFFF_FFFF, 4'd9}, 1'b1, NOROOM_RES},
    '{'{vlq_pkg::OP_ENCODE, 8'h00, 1'b0, 64'hFFFF_FFFF_FFFF_FFFF, 4'd15}, 1'b0, '0},
    '{'{vlq_pkg::OP_ENCODE, 8'h00, 1'b0, 64'h8000_0000_0000_0000, 4'd10}, 1'b0, '0}
  };

  logic clk;
  logic rst_n;

  vlq_in_if  in_ch ();
  vlq_out_if out_ch ();

  vlq_base128_codec DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // decode state of the predictor
  logic [63:0] dec_acc;
  logic [7:0]  dec_seen;

  vlq_result_t step_results[$];
  vlq_result_t awaited[$];
  int          fail_count;
  int          burst_left;
  bit          hold_off_req;

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // results of one item, updating the decode state
  function automatic void vlq_predict(input vlq_item_t it);
    logic [63:0] v;
    logic [63:0] t;
    int          n;
    vlq_result_t r;
    step_results.delete();
    if (it.op == vlq_pkg::OP_DECODE) begin
      dec_acc = ((dec_acc << 7) | {56'd0, it.data & vlq_pkg::GROUP_MASK}) & VALUE_MASK;
      if (dec_seen != 8'd255) dec_seen++;
      if ((it.data & vlq_pkg::MORE_BIT) == 8'd0) begin
        r = '{dec_acc, dec_seen, 8'h00, vlq_pkg::STAT_OK, 1'b1};
        step_results = {step_results, r};
        dec_acc = '0;
        dec_seen = '0;
      end else if (it.buf_end) begin
        r = '{dec_acc, 8'd0, 8'h00, vlq_pkg::STAT_TRUNC, 1'b1};
        step_results = {step_results, r};
        dec_acc = '0;
        dec_seen = '0;
      end
    end else begin
      v = it.value & VALUE_MASK;
      t = v >> 7;
      n = 1;
      while (t != 64'd0) begin
        n++;
        t = t >> 7;
      end
      if (it.room == 4'd0 || n > it.room) begin
        step_results = {step_results, NOROOM_RES};
      end else begin
        // groups go out most significant first, all but the last flagged
        for (int i = 0; i < n; i++) begin
          r.value = 64'd0;
          r.count = n[7:0];
          r.code = (8'(v >> (7 * (n - 1 - i))) & vlq_pkg::GROUP_MASK) |
                   ((i != n - 1) ? vlq_pkg::MORE_BIT : 8'h00);
          r.status = vlq_pkg::STAT_OK;
          r.last = (i == n - 1);
          step_results = {step_results, r};
        end
      end
    end
  endfunction

  function automatic vlq_item_t dec_item(input logic [7:0] b, input logic e);
    return '{vlq_pkg::OP_DECODE, b, e, {$urandom, $urandom}, 4'($urandom)};
  endfunction

  function automatic vlq_item_t enc_item(input logic [63:0] v, input logic [3:0] rm);
    return '{vlq_pkg::OP_ENCODE, 8'($urandom), 1'($urandom), v, rm};
  endfunction

  // values of every length, from one byte to ten
  function automatic logic [63:0] rand_enc_value();
    return {$urandom, $urandom} >> $urandom_range(0, 63);
  endfunction

  // offer one item in bursts with random gaps, then book its results
  task automatic send_item(input vlq_item_t it, input logic typed, input vlq_result_t want);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 8) : 0;
      if (gap > 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 16);
    end
    in_ch.valid       <= 1'b1;
    in_ch.op          <= it.op;
    in_ch.data_byte   <= it.data;
    in_ch.buffer_end  <= it.buf_end;
    in_ch.plain_value <= it.value;
    in_ch.room        <= it.room;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    burst_left--;
    vlq_predict(it);
    if (typed) begin
      awaited = {awaited, want};
    end else begin
      awaited = {awaited, step_results};
    end
  endtask

  // stimulus
  initial begin
    int len;
    int sent;
    in_ch.valid = 1'b0;
    in_ch.op = vlq_pkg::OP_DECODE;
    in_ch.data_byte = 8'h00;
    in_ch.buffer_end = 1'b0;
    in_ch.plain_value = 64'd0;
    in_ch.room = 4'd0;
    rst_n = 1'b0;
    fail_count = 0;
    burst_left = 0;
    hold_off_req = 1'b0;
    dec_acc = '0;
    dec_seen = '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    foreach (DIRECTED[i]) send_item(DIRECTED[i].item, DIRECTED[i].typed, DIRECTED[i].want);

    // overlong number: high groups fall out of the accumulator
    repeat (10) send_item(dec_item(8'hFF, 1'b0), 1'b0, '0);
    send_item(dec_item(8'h7F, 1'($urandom)), 1'b0, '0);

    // count saturation
    repeat (SAT_RUN) begin
      send_item(dec_item(vlq_pkg::MORE_BIT | 8'($urandom_range(0, 127)), 1'b0), 1'b0, '0);
    end
    send_item(dec_item(8'($urandom_range(0, 127)), 1'($urandom)), 1'b0, '0);

    // receiver held off while the mix below keeps coming
    hold_off_req = 1'b1;

    // random mix: mostly well-formed numbers and encodes, some noise
    sent = 0;
    while (sent < RAND_ITEMS) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4: begin
          len = $urandom_range(1, 12);
          for (int k = 0; k < len; k++) begin
            if ($urandom_range(0, 7) == 0) begin
              send_item(enc_item(rand_enc_value(), 4'($urandom)), 1'b0, '0);
              sent++;
            end
            if (k < len - 1) begin
              send_item(dec_item(vlq_pkg::MORE_BIT | 8'($urandom_range(0, 127)), 1'b0),
                        1'b0, '0);
            end else if ($urandom_range(0, 5) == 0) begin
              send_item(dec_item(vlq_pkg::MORE_BIT | 8'($urandom_range(0, 127)), 1'b1),
                        1'b0, '0);
            end else begin
              send_item(dec_item(8'($urandom_range(0, 127)), 1'($urandom)), 1'b0, '0);
            end
            sent++;
          end
        end
        5, 6, 7: begin
          send_item(enc_item(rand_enc_value(), 4'($urandom_range(0, 15))), 1'b0, '0);
          sent++;
        end
        default: begin
          if ($urandom_range(0, 1) == 0) begin
            send_item(dec_item(8'($urandom), 1'($urandom)), 1'b0, '0);
          end else begin
            send_item(enc_item({$urandom, $urandom}, 4'($urandom)), 1'b0, '0);
          end
          sent++;
        end
      endcase
    end
    in_ch.valid <= 1'b0;

    // drain
    while (awaited.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fail_count == 0 && awaited.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // receiver stall patterns, plus one long hold-off on request
  initial begin
    rx_mode_t mode;
    int       phase_len;
    out_ch.ready = 1'b0;
    forever begin
      mode = rx_mode_t'($urandom_range(0, 3));
      phase_len = $urandom_range(10, 60);
      for (int k = 0; k < phase_len; k++) begin
        @(posedge clk);
        if (hold_off_req) begin
          hold_off_req = 1'b0;
          out_ch.ready <= 1'b0;
          repeat (HOLD_CYCLES) @(posedge clk);
        end
        case (mode)
          RX_OPEN:   out_ch.ready <= 1'b1;
          RX_MOSTLY: out_ch.ready <= ($urandom_range(0, 3) != 0);
          RX_COIN:   out_ch.ready <= 1'($urandom_range(0, 1));
          default:   out_ch.ready <= (k % 4 == 0);
        endcase
      end
    end
  end

  // result checking against the oldest expectation
  always @(posedge clk) begin
    vlq_result_t got;
    vlq_result_t want;
    string       bad;
    if (rst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      got = '{out_ch.decoded_value, out_ch.byte_count, out_ch.code_byte,
              vlq_pkg::stat_t'(out_ch.status), out_ch.last};
      if (awaited.size() == 0) begin
        fail_count++;
        if (fail_count <= 10)
          $display("unexpected result: value %h count %0d code %h status %0d last %b",
                   got.value, got.count, got.code, got.status, got.last);
      end else begin
        want = awaited[0];
        awaited.delete(0);
        bad = "";
        if (got.value !== want.value) bad = {bad, " decoded_value"};
        if (got.count !== want.count) bad = {bad, " byte_count"};
        if (got.code !== want.code) bad = {bad, " code_byte"};
        if (got.status !== want.status) bad = {bad, " status"};
        if (got.last !== want.last) bad = {bad, " last"};
        if (bad != "") begin
          fail_count++;
          if (fail_count <= 10) begin
            $display("mismatch in%s", bad);
            $display("  expected value %h count %0d code %h status %0d last %b",
                     want.value, want.count, want.code, want.status, want.last);
            $display("  actual   value %h count %0d code %h status %0d last %b",
                     got.value, got.count, got.code, got.status, got.last);
          end
        end
      end
    end
  end

  // run limit
  initial begin
    #(LIMIT_NS);
    $display("CHECK FAILED");
    $finish;
  end

endmodule

/* filelist.f */
+incdir+rtl
rtl/vlq_pkg.sv
rtl/vlq_in_if.sv
rtl/vlq_out_if.sv
rtl/vlq_ctrl.sv
rtl/vlq_dp.sv
rtl/vlq_base128_codec.sv
dv/vlq_base128_codec_test.sv
